// File: rtl/matrix_power_series_mod10_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the matrix power series block
// Checks are compiled in unless ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MATRIX_POWER_SERIES_MOD10_DEFINES_SVH
`define MATRIX_POWER_SERIES_MOD10_DEFINES_SVH

`ifndef ASSERT_OFF
`define MPSM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define MPSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MPSM_ASSERT_IMP(lbl, ante, cons)
`define MPSM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/mpsm_pkg.sv
// ----------------------------------------------------------------------------
// mpsm_pkg
// Shared types, codes and mod 10 helpers of the matrix power series block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpsm_pkg;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_READ  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic REG_DIM = 1'b0;
    localparam logic REG_EXP = 1'b1;

    typedef enum logic [2:0] {
        PASS_CLEAR,
        PASS_INIT,
        PASS_MUL_PS,
        PASS_ADD,
        PASS_MUL_PP,
        PASS_MOVE,
        PASS_MUL_PA,
        PASS_MOVE_ADD
    } pass_t;

    typedef struct packed {
        logic       go;
        pass_t      mode;
        logic [6:0] n;
        logic       load_we;
        logic [5:0] row;
        logic [5:0] col;
        logic [3:0] load_val;
    } ctl_cmd_t;

    typedef struct packed {
        logic       pass_done;
        logic [3:0] rd_data;
    } dp_stat_t;

    // reciprocal 205/2048, exact for values below 1029
    function automatic logic [3:0] mod10_small(input logic [6:0] v);
        logic [14:0] prod;
        logic [6:0]  r;
        prod = 15'(v) * 15'd205;
        r = v - 7'(prod[14:11]) * 7'd10;
        return r[3:0];
    endfunction

    // reciprocal 52429/2^19, exact over 16 bits
    function automatic logic [3:0] mod10_wide(input logic [15:0] v);
        logic [31:0] prod;
        logic [15:0] r;
        prod = 32'(v) * 32'd52429;
        r = v - 16'(prod[31:19]) * 16'd10;
        return r[3:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/mpsm_datapath.sv
// ----------------------------------------------------------------------------
// mpsm_datapath
// Matrix stores and a pass engine: one multiply-accumulate or one element
// update per cycle, three stages from address to write.
// ----------------------------------------------------------------------------
`default_nettype none

module mpsm_datapath import mpsm_pkg::*; #(
    parameter int MAX_DIM = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire ctl_cmd_t cmd,
    output dp_stat_t      stat
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;

    logic [3:0] src_mem [DEPTH];
    logic [3:0] pwr_mem [DEPTH];
    logic [3:0] sum_mem [DEPTH];
    logic [3:0] scr_mem [DEPTH];

    logic          active_reg, run_reg, done_reg, v1_reg, v2_reg;
    pass_t         mode_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic          first1_reg, last1_reg, first2_reg, last2_reg;
    logic [AW-1:0] dst1_reg, dst2_reg;
    logic [3:0]    pwr_a_rd_reg, pwr_b_rd_reg, src_rd_reg, sum_rd_reg, scr_rd_reg;
    logic [6:0]    p_reg;
    logic [3:0]    c_reg, acc_reg;

    logic          is_mul, last_i, last_j, last_k;
    logic          wr_pwr, wr_sum;
    logic [AW-1:0] a_ik, a_kj, a_ij, sum_addr;
    logic [6:0]    p_next, acc_sum;
    logic [3:0]    acc_next;

    assign is_mul = (mode_reg inside {PASS_MUL_PS, PASS_MUL_PP, PASS_MUL_PA});
    assign last_i = (7'(i_reg) == cmd.n - 7'd1);
    assign last_j = (7'(j_reg) == cmd.n - 7'd1);
    assign last_k = !is_mul || (7'(k_reg) == cmd.n - 7'd1);
    assign a_ik   = {i_reg, k_reg};
    assign a_kj   = {k_reg, j_reg};
    assign a_ij   = {i_reg, j_reg};
    assign sum_addr = active_reg ? (is_mul ? a_kj : a_ij)
                                 : {cmd.row[IW-1:0], cmd.col[IW-1:0]};
    assign wr_pwr = (mode_reg inside {PASS_INIT, PASS_MOVE, PASS_MOVE_ADD});
    assign wr_sum = (mode_reg inside {PASS_CLEAR, PASS_INIT, PASS_ADD, PASS_MOVE_ADD});

    always_comb
    begin
        case (mode_reg)
            PASS_MUL_PS:   p_next = 7'(pwr_a_rd_reg) * 7'(sum_rd_reg);
            PASS_MUL_PP:   p_next = 7'(pwr_a_rd_reg) * 7'(pwr_b_rd_reg);
            PASS_MUL_PA:   p_next = 7'(pwr_a_rd_reg) * 7'(src_rd_reg);
            PASS_ADD,
            PASS_MOVE_ADD: p_next = 7'(sum_rd_reg) + 7'(scr_rd_reg);
            PASS_INIT:     p_next = 7'(src_rd_reg);
            default:       p_next = 7'd0;
        endcase
    end

    assign acc_sum  = first2_reg ? p_reg : 7'(acc_reg) + p_reg;
    assign acc_next = mod10_small(acc_sum);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            run_reg    <= 1'b0;
            done_reg   <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            mode_reg   <= PASS_CLEAR;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            v1_reg   <= run_reg;
            v2_reg   <= v1_reg;
            if (cmd.go)
            begin
                active_reg <= 1'b1;
                run_reg    <= 1'b1;
                mode_reg   <= cmd.mode;
                i_reg      <= '0;
                j_reg      <= '0;
                k_reg      <= '0;
            end
            else if (run_reg)
            begin
                if (!last_k)
                    k_reg <= k_reg + IW'(1);
                else
                begin
                    k_reg <= '0;
                    if (!last_j)
                        j_reg <= j_reg + IW'(1);
                    else
                    begin
                        j_reg <= '0;
                        if (last_i)
                            run_reg <= 1'b0;
                        else
                            i_reg <= i_reg + IW'(1);
                    end
                end
            end
            else if (active_reg && !v1_reg && !v2_reg)
            begin
                active_reg <= 1'b0;
                done_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pwr_a_rd_reg <= pwr_mem[a_ik];
        pwr_b_rd_reg <= pwr_mem[a_kj];
        src_rd_reg   <= src_mem[is_mul ? a_kj : a_ij];
        sum_rd_reg   <= sum_mem[sum_addr];
        scr_rd_reg   <= scr_mem[a_ij];
        first1_reg   <= (k_reg == '0);
        last1_reg    <= last_k;
        dst1_reg     <= a_ij;
        first2_reg   <= first1_reg;
        last2_reg    <= last1_reg;
        dst2_reg     <= dst1_reg;
        p_reg        <= p_next;
        c_reg        <= (mode_reg == PASS_INIT) ? src_rd_reg : scr_rd_reg;
        if (v2_reg)
            acc_reg <= acc_next;
        if (cmd.load_we)
            src_mem[{cmd.row[IW-1:0], cmd.col[IW-1:0]}] <= cmd.load_val;
        if (v2_reg && is_mul && last2_reg)
            scr_mem[dst2_reg] <= acc_next;
        if (v2_reg && wr_pwr)
            pwr_mem[dst2_reg] <= c_reg;
        if (v2_reg && wr_sum)
            sum_mem[dst2_reg] <= mod10_small(p_reg);
    end

    assign stat.pass_done = done_reg;
    assign stat.rd_data   = sum_rd_reg;

endmodule

`default_nettype wire

// File: rtl/mpsm_ctrl.sv
// ----------------------------------------------------------------------------
// mpsm_ctrl
// Configuration registers, command decode and the pass sequencer that
// walks the exponent bits from the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_power_series_mod10_defines.svh"

module mpsm_ctrl import mpsm_pkg::*; #(
    parameter int MAX_DIM  = 64,
    parameter int EXP_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [5:0]  row,
    input  wire logic [5:0]  col,
    input  wire logic [15:0] element_value,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             result_valid,
    output logic [1:0]       status,
    output logic [3:0]       result_value,
    output ctl_cmd_t         cmd,
    input  wire dp_stat_t    stat
);

    localparam int CW = $clog2(EXP_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_WAIT
    } state_t;

    state_t              state_reg;
    logic [6:0]          dim_reg;
    logic [EXP_BITS-1:0] exp_reg, k_reg;
    logic [CW-1:0]       bits_reg;
    logic                bit_reg, go_reg, valid_reg;
    pass_t               mode_reg;
    logic [1:0]          status_reg;

    logic [6:0]          n;
    logic                accept, in_range, iter_end;
    logic [EXP_BITS-1:0] k_shift;

    assign n        = (dim_reg > 7'(MAX_DIM)) ? 7'(MAX_DIM) : dim_reg;
    assign accept   = start && (state_reg == ST_IDLE);
    assign in_range = ({1'b0, row} < n) && ({1'b0, col} < n);
    assign k_shift  = k_reg << 1;
    assign iter_end = (mode_reg inside {PASS_INIT, PASS_MOVE_ADD})
                      || ((mode_reg == PASS_MOVE) && !bit_reg);

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign result_value = (valid_reg && status_reg == STAT_READ) ? stat.rd_data : 4'd0;

    assign cmd.go       = go_reg;
    assign cmd.mode     = mode_reg;
    assign cmd.n        = n;
    assign cmd.load_we  = accept && (opcode == OP_LOAD) && in_range;
    assign cmd.row      = row;
    assign cmd.col      = col;
    assign cmd.load_val = mod10_wide(element_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dim_reg    <= 7'd1;
            exp_reg    <= EXP_BITS'(1);
            k_reg      <= '0;
            bits_reg   <= '0;
            bit_reg    <= 1'b0;
            go_reg     <= 1'b0;
            valid_reg  <= 1'b0;
            mode_reg   <= PASS_CLEAR;
            status_reg <= STAT_DONE;
        end
        else
        begin
            go_reg    <= 1'b0;
            valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIM: dim_reg <= cfg_data[6:0];
                    REG_EXP: exp_reg <= cfg_data[EXP_BITS-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (opcode)
                            OP_LOAD:
                            begin
                                if (!in_range)
                                begin
                                    valid_reg  <= 1'b1;
                                    status_reg <= STAT_RANGE;
                                end
                            end
                            OP_COMPUTE:
                            begin
                                if (n == 7'd0)
                                begin
                                    valid_reg  <= 1'b1;
                                    status_reg <= STAT_DONE;
                                end
                                else if (exp_reg == '0)
                                begin
                                    go_reg    <= 1'b1;
                                    mode_reg  <= PASS_CLEAR;
                                    state_reg <= ST_WAIT;
                                end
                                else
                                begin
                                    k_reg     <= exp_reg;
                                    bits_reg  <= CW'(EXP_BITS - 1);
                                    state_reg <= ST_SEEK;
                                end
                            end
                            OP_READ:
                            begin
                                valid_reg  <= 1'b1;
                                status_reg <= in_range ? STAT_READ : STAT_RANGE;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SEEK:
                begin
                    if (k_reg[EXP_BITS-1])
                    begin
                        go_reg    <= 1'b1;
                        mode_reg  <= PASS_INIT;
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        k_reg    <= k_shift;
                        bits_reg <= bits_reg - CW'(1);
                    end
                end
                ST_WAIT:
                begin
                    if (stat.pass_done)
                    begin
                        if (mode_reg == PASS_CLEAR || (iter_end && bits_reg == '0))
                        begin
                            valid_reg  <= 1'b1;
                            status_reg <= STAT_DONE;
                            state_reg  <= ST_IDLE;
                        end
                        else if (iter_end)
                        begin
                            k_reg    <= k_shift;
                            bits_reg <= bits_reg - CW'(1);
                            bit_reg  <= k_shift[EXP_BITS-1];
                            go_reg   <= 1'b1;
                            mode_reg <= PASS_MUL_PS;
                        end
                        else
                        begin
                            go_reg <= 1'b1;
                            case (mode_reg)
                                PASS_MUL_PS: mode_reg <= PASS_ADD;
                                PASS_ADD:    mode_reg <= PASS_MUL_PP;
                                PASS_MUL_PP: mode_reg <= PASS_MOVE;
                                PASS_MOVE:   mode_reg <= PASS_MUL_PA;
                                PASS_MUL_PA: mode_reg <= PASS_MOVE_ADD;
                                default:     mode_reg <= PASS_CLEAR;
                            endcase
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `MPSM_ASSERT_IMP(a_result_when_idle, valid_reg, state_reg == ST_IDLE)
    `MPSM_ASSERT_IMP(a_go_only_waiting, go_reg, state_reg == ST_WAIT)
    `MPSM_ASSERT_NEXT(a_read_answers, accept && opcode == OP_READ, valid_reg)

endmodule

`default_nettype wire

// File: rtl/matrix_power_series_mod10.sv
// ----------------------------------------------------------------------------
// matrix_power_series_mod10
// Matrix series A + A^2 + ... + A^k mod 10 with load, compute and read items.
// ----------------------------------------------------------------------------
// A load answers only when its index is out of range; a read answers with
// its result in the next cycle. A compute keeps busy high while a single
// multiply-accumulate unit makes one product per cycle within a pass. After
// the sequencer finds the top bit of k, each lower bit of k costs 2 products
// and 2 element passes, plus one more of each when that bit is set. Results
// are strobed on result_valid for one cycle and must be taken then: there is
// no hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_power_series_mod10 import mpsm_pkg::*; #(
    parameter int MAX_DIM  = 64,
    parameter int EXP_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [5:0]  row,
    input  wire logic [5:0]  col,
    input  wire logic [15:0] element_value,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             result_valid,
    output logic [1:0]       status,
    output logic [3:0]       result_value
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    mpsm_ctrl #(
        .MAX_DIM  (MAX_DIM),
        .EXP_BITS (EXP_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .row           (row),
        .col           (col),
        .element_value (element_value),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .status        (status),
        .result_value  (result_value),
        .cmd           (cmd),
        .stat          (stat)
    );

    mpsm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule

`default_nettype wire
